@@ rtl/core/dbrd_pkg.sv @@
// Shared types and constants for the reply header deframer.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dbrd_pkg;

    // Section sizes of the fixed message prefix
    localparam int LEN_BYTES    = 4;
    localparam int HDR_BYTES    = 12;
    localparam int FLD_BYTES    = 20;
    localparam int PREFIX_BYTES = LEN_BYTES + HDR_BYTES + FLD_BYTES;

    // Last section index of each prefix section
    localparam logic [4:0] LEN_LAST = 5'(LEN_BYTES - 1);
    localparam logic [4:0] HDR_LAST = 5'(HDR_BYTES - 1);
    localparam logic [4:0] FLD_LAST = 5'(FLD_BYTES - 1);

    // Byte offsets inside the field section
    localparam logic [4:0] FLD_CURSOR_AT = 5'd4;
    localparam logic [4:0] FLD_START_AT  = 5'd12;
    localparam logic [4:0] FLD_COUNT_AT  = 5'd16;

    localparam logic [31:0] PREFIX_LEN = 32'(PREFIX_BYTES);

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Status codes
    localparam logic [1:0] ST_PREFIX = 2'd0;
    localparam logic [1:0] ST_BODY   = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;
    localparam logic [1:0] ST_ERROR  = 2'd3;

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_FLD  = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    // Input payload
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_of_chunk;
    } in_t;

    // Result payload
    typedef struct packed {
        logic signed [31:0] message_length;
        logic [31:0]        request_id;
        logic [31:0]        response_to;
        logic [31:0]        op_code;
        logic [31:0]        response_flags;
        logic [63:0]        cursor_id;
        logic [31:0]        starting_from;
        logic [31:0]        number_returned;
        logic [7:0]         body_byte;
        logic               body_valid;
        logic [1:0]         status;
        logic               chunk_accepted;
    } out_t;

    // Classified byte handed from front to back
    typedef struct packed {
        phase_t     kind;
        logic [4:0] idx;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } op_t;

endpackage

`default_nettype wire

@@ rtl/core/db_reply_header_deframer.sv @@
// Reply header deframer for a document database wire protocol.
// Top level; depends on dbrd_pkg, dbrd_front, dbrd_queue, dbrd_back.
//
// Usage:
//   byte_valid/byte_ready/byte_data carry one reply byte per transfer,
//   with last_of_chunk marking the end of a delivered chunk.
//   result_valid/result_ready/result carry one result per input byte:
//   the length, header and field words as filled so far, the body byte
//   when the byte is part of the body, the status and the chunk flag.
//   A length below 36 reports a length error and restarts length capture.
// Path: each transferred byte is registered in the queue entry, then in
//   the result register; result_valid rises once the result register holds it.
// Throughput: one byte per cycle while byte_ready is high; the front tracks
//   phase with plain counters and the back updates one byte lane per cycle
//   while its result slot is empty or being drained.
// Stall: the queue between front and back plus the result register absorb
//   a stalled receiver; byte_ready drops only once the queue is full.
// Reset: all words read zero, the block waits for the first length byte.
`timescale 1ns / 1ps
`default_nettype none

module db_reply_header_deframer
#(
    parameter int QUEUE_DEPTH = dbrd_pkg::QUEUE_DEPTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            byte_valid,
    output logic                 byte_ready,
    input  wire dbrd_pkg::in_t   byte_data,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output dbrd_pkg::out_t       result
);

    dbrd_pkg::op_t push_op;
    dbrd_pkg::op_t head_op;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;

    // Front: phase tracking and classification
    dbrd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (push_op)
    );

    // Queue between front and back
    dbrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (head_op)
    );

    // Back: word assembly and result register
    dbrd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (q_valid),
        .op           (head_op),
        .op_pop       (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ rtl/core/dbrd_front.sv @@
// Front end: accepts bytes, tracks phase and counters, classifies each byte.
// Depends on dbrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbrd_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           byte_valid,
    output logic                byte_ready,
    input  wire dbrd_pkg::in_t  byte_data,
    input  wire logic           q_full,
    output logic                q_push,
    output dbrd_pkg::op_t       q_op
);

    dbrd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]       count_reg, count_next;
    logic [31:0]      body_cnt_reg, body_cnt_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      target_reg, target_next;
    logic [31:0]      body_cnt_inc;
    logic             accept;

    assign byte_ready   = !q_full;
    assign accept       = byte_valid && byte_ready;
    assign q_push       = accept;
    assign body_cnt_inc = body_cnt_reg + 32'd1;

    // Phase sequencing and byte classification
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        body_cnt_next = body_cnt_reg;
        len_next      = len_reg;
        target_next   = target_reg;
        q_op.kind     = phase_reg;
        q_op.idx      = count_reg;
        q_op.data     = byte_data.byte_in;
        q_op.last     = byte_data.last_of_chunk;
        q_op.status   = dbrd_pkg::ST_PREFIX;

        unique case (phase_reg)
            dbrd_pkg::PH_LEN:
            begin
                len_next[count_reg[1:0]*8 +: 8] = byte_data.byte_in;
                if (count_reg == dbrd_pkg::LEN_LAST)
                begin
                    count_next = '0;
                    if (len_next[31] || (len_next < dbrd_pkg::PREFIX_LEN))
                    begin
                        q_op.status = dbrd_pkg::ST_ERROR;
                    end
                    else
                    begin
                        phase_next  = dbrd_pkg::PH_HDR;
                        target_next = len_next - dbrd_pkg::PREFIX_LEN;
                    end
                end
                else
                begin
                    count_next = count_reg + 5'd1;
                end
            end
            dbrd_pkg::PH_HDR:
            begin
                if (count_reg == dbrd_pkg::HDR_LAST)
                begin
                    count_next = '0;
                    phase_next = dbrd_pkg::PH_FLD;
                end
                else
                begin
                    count_next = count_reg + 5'd1;
                end
            end
            dbrd_pkg::PH_FLD:
            begin
                if (count_reg == dbrd_pkg::FLD_LAST)
                begin
                    count_next    = '0;
                    body_cnt_next = '0;
                    if (target_reg == 32'd0)
                    begin
                        q_op.status = dbrd_pkg::ST_DONE;
                        phase_next  = dbrd_pkg::PH_LEN;
                    end
                    else
                    begin
                        q_op.status = dbrd_pkg::ST_BODY;
                        phase_next  = dbrd_pkg::PH_BODY;
                    end
                end
                else
                begin
                    count_next = count_reg + 5'd1;
                end
            end
            dbrd_pkg::PH_BODY:
            begin
                if (body_cnt_inc == target_reg)
                begin
                    q_op.status   = dbrd_pkg::ST_DONE;
                    phase_next    = dbrd_pkg::PH_LEN;
                    body_cnt_next = '0;
                    count_next    = '0;
                end
                else
                begin
                    q_op.status   = dbrd_pkg::ST_BODY;
                    body_cnt_next = body_cnt_inc;
                end
            end
            default:
            begin
                phase_next = dbrd_pkg::PH_LEN;
                count_next = '0;
            end
        endcase
    end

    // State registers advance only on a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= dbrd_pkg::PH_LEN;
            count_reg    <= '0;
            body_cnt_reg <= '0;
            len_reg      <= '0;
            target_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            body_cnt_reg <= body_cnt_next;
            len_reg      <= len_next;
            target_reg   <= target_next;
        end
    end

    // Section index never runs past the field section
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dbrd_pkg::FLD_LAST)
        else $error("section index out of range");

    // Counters are cleared whenever a message has just ended
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && q_op.status == dbrd_pkg::ST_DONE) |=>
        (count_reg == 5'd0 && body_cnt_reg == 32'd0 && phase_reg == dbrd_pkg::PH_LEN))
        else $error("counters not cleared after message end");

endmodule

`default_nettype wire

@@ rtl/core/dbrd_queue.sv @@
// Short FIFO of classified bytes between front and back.
// Depends on dbrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbrd_queue
#(
    parameter int DEPTH = dbrd_pkg::QUEUE_DEPTH
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dbrd_pkg::op_t  push_op,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output dbrd_pkg::op_t       head_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dbrd_pkg::op_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // Never written while full, never read while empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !head_valid))
        else $error("queue overflow or underflow");

endmodule

`default_nettype wire

@@ rtl/core/dbrd_back.sv @@
// Back end: applies classified bytes to the field words, holds the result.
// Depends on dbrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dbrd_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           op_valid,
    input  wire dbrd_pkg::op_t  op,
    output logic                op_pop,
    output logic                result_valid,
    input  wire logic           result_ready,
    output dbrd_pkg::out_t      result
);

    logic [31:0] len_reg, len_next;
    logic [31:0] hdr_reg [3];
    logic [31:0] hdr_next [3];
    logic [31:0] flags_reg, flags_next;
    logic [63:0] cursor_reg, cursor_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] number_reg, number_next;
    logic [7:0]  body_byte_reg, body_byte_next;
    logic        body_valid_reg, body_valid_next;
    logic [1:0]  status_reg;
    logic        chunk_reg, chunk_next;
    logic        valid_reg;
    logic [4:0]  cursor_off;

    // Load a new result when the output slot is empty or being drained
    assign op_pop     = op_valid && (!valid_reg || result_ready);
    assign cursor_off = op.idx - dbrd_pkg::FLD_CURSOR_AT;

    // Byte lane updates
    always_comb
    begin
        len_next        = len_reg;
        hdr_next        = hdr_reg;
        flags_next      = flags_reg;
        cursor_next     = cursor_reg;
        start_next      = start_reg;
        number_next     = number_reg;
        body_byte_next  = 8'd0;
        body_valid_next = 1'b0;
        chunk_next      = op.last && (op.status == dbrd_pkg::ST_DONE);

        unique case (op.kind)
            dbrd_pkg::PH_LEN:
            begin
                len_next[op.idx[1:0]*8 +: 8] = op.data;
            end
            dbrd_pkg::PH_HDR:
            begin
                unique case (op.idx[3:2])
                    2'd0: hdr_next[0][op.idx[1:0]*8 +: 8] = op.data;
                    2'd1: hdr_next[1][op.idx[1:0]*8 +: 8] = op.data;
                    2'd2: hdr_next[2][op.idx[1:0]*8 +: 8] = op.data;
                    default: hdr_next[2] = hdr_reg[2];
                endcase
            end
            dbrd_pkg::PH_FLD:
            begin
                priority if (op.idx < dbrd_pkg::FLD_CURSOR_AT)
                begin
                    flags_next[op.idx[1:0]*8 +: 8] = op.data;
                end
                else if (op.idx < dbrd_pkg::FLD_START_AT)
                begin
                    cursor_next[cursor_off[2:0]*8 +: 8] = op.data;
                end
                else if (op.idx < dbrd_pkg::FLD_COUNT_AT)
                begin
                    start_next[op.idx[1:0]*8 +: 8] = op.data;
                end
                else
                begin
                    number_next[op.idx[1:0]*8 +: 8] = op.data;
                end
            end
            dbrd_pkg::PH_BODY:
            begin
                body_byte_next  = op.data;
                body_valid_next = 1'b1;
            end
            default:
            begin
                body_valid_next = 1'b0;
            end
        endcase
    end

    // Field words and result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            hdr_reg[0]     <= '0;
            hdr_reg[1]     <= '0;
            hdr_reg[2]     <= '0;
            flags_reg      <= '0;
            cursor_reg     <= '0;
            start_reg      <= '0;
            number_reg     <= '0;
            valid_reg      <= 1'b0;
            body_byte_reg  <= '0;
            body_valid_reg <= 1'b0;
            status_reg     <= dbrd_pkg::ST_PREFIX;
            chunk_reg      <= 1'b0;
        end
        else
        begin
            if (op_pop)
            begin
                len_reg        <= len_next;
                hdr_reg        <= hdr_next;
                flags_reg      <= flags_next;
                cursor_reg     <= cursor_next;
                start_reg      <= start_next;
                number_reg     <= number_next;
                body_byte_reg  <= body_byte_next;
                body_valid_reg <= body_valid_next;
                status_reg     <= op.status;
                chunk_reg      <= chunk_next;
                valid_reg      <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid           = valid_reg;
    assign result.message_length  = $signed(len_reg);
    assign result.request_id      = hdr_reg[0];
    assign result.response_to     = hdr_reg[1];
    assign result.op_code         = hdr_reg[2];
    assign result.response_flags  = flags_reg;
    assign result.cursor_id       = cursor_reg;
    assign result.starting_from   = start_reg;
    assign result.number_returned = number_reg;
    assign result.body_byte       = body_byte_reg;
    assign result.body_valid      = body_valid_reg;
    assign result.status          = status_reg;
    assign result.chunk_accepted  = chunk_reg;

    // Field words must not move under a stalled result
    a_hold_words: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_ready) |=>
        ($stable(len_reg) && $stable(cursor_reg) && $stable(flags_reg)
         && $stable(number_reg) && $stable(start_reg)))
        else $error("field words changed while result stalled");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the reply header deframer (db_reply_header_deframer).
// Depends on dbrd_pkg and the RTL under rtl/core; predicts each result from its own
// model of the byte-level framing and compares every result transfer field by field.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BYTES = 700;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_ready;
    dbrd_pkg::in_t byte_data = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    dbrd_pkg::out_t result;

    // Predictor state
    dbrd_pkg::phase_t frame_phase = dbrd_pkg::PH_LEN;
    logic [4:0] section_idx = '0;
    logic [31:0] body_seen = '0;
    logic [31:0] length_word = '0;
    logic [31:0] header_word [3] = '{default: '0};
    logic [31:0] field_word [3] = '{default: '0};
    logic [63:0] cursor_word = '0;

    dbrd_pkg::out_t expected_replies [$];
    int mismatches = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    bit no_idle = 1'b0;

    db_reply_header_deframer DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Framing model: one expected result per transferred byte
    function automatic dbrd_pkg::out_t predict_reply(dbrd_pkg::in_t item);
        dbrd_pkg::out_t r;
        logic [1:0] st;
        logic bvalid;
        int idx;
        int lane;
        st = dbrd_pkg::ST_PREFIX;
        bvalid = 1'b0;
        idx = int'(section_idx);
        r = '0;
        case (frame_phase)
            dbrd_pkg::PH_LEN:
            begin
                lane = idx % 4;
                length_word[lane*8 +: 8] = item.byte_in;
                section_idx = 5'(idx + 1);
                if (idx + 1 >= dbrd_pkg::LEN_BYTES)
                begin
                    section_idx = '0;
                    if (length_word[31] || length_word < dbrd_pkg::PREFIX_LEN)
                        st = dbrd_pkg::ST_ERROR;
                    else
                        frame_phase = dbrd_pkg::PH_HDR;
                end
            end
            dbrd_pkg::PH_HDR:
            begin
                lane = idx % 4;
                header_word[idx / 4][lane*8 +: 8] = item.byte_in;
                section_idx = 5'(idx + 1);
                if (idx + 1 >= dbrd_pkg::HDR_BYTES)
                begin
                    section_idx = '0;
                    frame_phase = dbrd_pkg::PH_FLD;
                end
            end
            dbrd_pkg::PH_FLD:
            begin
                lane = idx % 4;
                if (idx < int'(dbrd_pkg::FLD_CURSOR_AT))
                    field_word[0][lane*8 +: 8] = item.byte_in;
                else if (idx < int'(dbrd_pkg::FLD_START_AT))
                    cursor_word[(idx - int'(dbrd_pkg::FLD_CURSOR_AT))*8 +: 8] = item.byte_in;
                else if (idx < int'(dbrd_pkg::FLD_COUNT_AT))
                    field_word[1][lane*8 +: 8] = item.byte_in;
                else
                    field_word[2][lane*8 +: 8] = item.byte_in;
                section_idx = 5'(idx + 1);
                if (idx + 1 >= dbrd_pkg::FLD_BYTES)
                begin
                    section_idx = '0;
                    body_seen = '0;
                    if (length_word == dbrd_pkg::PREFIX_LEN)
                    begin
                        st = dbrd_pkg::ST_DONE;
                        frame_phase = dbrd_pkg::PH_LEN;
                    end
                    else
                    begin
                        st = dbrd_pkg::ST_BODY;
                        frame_phase = dbrd_pkg::PH_BODY;
                    end
                end
            end
            default:
            begin
                bvalid = 1'b1;
                body_seen = body_seen + 32'd1;
                if (body_seen == length_word - dbrd_pkg::PREFIX_LEN)
                begin
                    st = dbrd_pkg::ST_DONE;
                    frame_phase = dbrd_pkg::PH_LEN;
                    body_seen = '0;
                    section_idx = '0;
                end
                else
                    st = dbrd_pkg::ST_BODY;
            end
        endcase
        r.message_length  = length_word;
        r.request_id      = header_word[0];
        r.response_to     = header_word[1];
        r.op_code         = header_word[2];
        r.response_flags  = field_word[0];
        r.cursor_id       = cursor_word;
        r.starting_from   = field_word[1];
        r.number_returned = field_word[2];
        r.body_byte       = bvalid ? item.byte_in : 8'd0;
        r.body_valid      = bvalid;
        r.status          = st;
        r.chunk_accepted  = item.last_of_chunk && (st == dbrd_pkg::ST_DONE);
        return r;
    endfunction

    // Send one byte; may idle first, then holds valid until the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        dbrd_pkg::out_t exp_reply;
        if (!no_idle && $urandom_range(99) < 33)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_data.byte_in = b;
        byte_data.last_of_chunk = last;
        byte_valid = 1'b1;
        do
            @(posedge clk);
        while (!byte_ready);
        exp_reply = predict_reply(byte_data);
        expected_replies = {expected_replies, exp_reply};
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_length(input logic [31:0] len, input logic last);
        for (int i = 0; i < dbrd_pkg::LEN_BYTES; i++)
            send_byte(len[i*8 +: 8], (i == dbrd_pkg::LEN_BYTES - 1) ? last : 1'b0);
    endtask

    // Well-formed reply with random header, fields and body
    task automatic send_message(input int body_len);
        int total;
        total = dbrd_pkg::PREFIX_BYTES + body_len;
        send_length(32'(total), ($urandom_range(7) == 0));
        for (int i = dbrd_pkg::LEN_BYTES; i < total; i++)
        begin
            if (i == total - 1)
                send_byte(8'($urandom), 1'($urandom_range(1)));
            else
                send_byte(8'($urandom), ($urandom_range(7) == 0));
        end
    endtask

    // Compare one field and report a mismatch
    task automatic check_field(input string name, input logic [63:0] exp,
                               input logic [63:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $realtime, name, exp, act);
            mismatches++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        dbrd_pkg::out_t exp;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result transfer: expected none actual %h",
                         $realtime, result);
                mismatches++;
            end
            else
            begin
                exp = expected_replies.pop_front();
                check_field("message_length", 64'(exp.message_length),
                            64'(result.message_length));
                check_field("request_id", 64'(exp.request_id), 64'(result.request_id));
                check_field("response_to", 64'(exp.response_to), 64'(result.response_to));
                check_field("op_code", 64'(exp.op_code), 64'(result.op_code));
                check_field("response_flags", 64'(exp.response_flags),
                            64'(result.response_flags));
                check_field("cursor_id", exp.cursor_id, result.cursor_id);
                check_field("starting_from", 64'(exp.starting_from),
                            64'(result.starting_from));
                check_field("number_returned", 64'(exp.number_returned),
                            64'(result.number_returned));
                check_field("body_byte", 64'(exp.body_byte), 64'(result.body_byte));
                check_field("body_valid", 64'(exp.body_valid), 64'(result.body_valid));
                check_field("status", 64'(exp.status), 64'(result.status));
                check_field("chunk_accepted", 64'(exp.chunk_accepted),
                            64'(result.chunk_accepted));
            end
        end
    end

    // Receiver: stalls about a quarter of the cycles unless in a steady stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready = 1'b0;
        else
            result_ready = no_idle ? 1'b1 : ($urandom_range(99) >= 25);
    end

    // Lengths of zero, negative, just below the prefix and all ones
    task automatic test_short_lengths();
        send_length(32'h0000_0000, 1'b1);
        send_length(32'h8000_0000, 1'b0);
        send_length(dbrd_pkg::PREFIX_LEN - 32'd1, 1'b1);
        send_length(32'hFFFF_FFFF, 1'b1);
    endtask

    // Empty body, alternating extreme bytes, then a one-byte body
    task automatic test_empty_body();
        send_length(dbrd_pkg::PREFIX_LEN, 1'b0);
        for (int i = dbrd_pkg::LEN_BYTES; i < dbrd_pkg::PREFIX_BYTES; i++)
            send_byte((i % 2) ? 8'hFF : 8'h00, (i == dbrd_pkg::PREFIX_BYTES - 1));
        send_message(1);
    endtask

    // Mostly well-formed replies, some short-length noise, one steady stretch
    task automatic test_random_traffic();
        int start;
        int pick;
        logic [31:0] bad_len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            no_idle = (bytes_sent - start >= 300) && (bytes_sent - start < 500);
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                bad_len = $urandom;
                if (!bad_len[31])
                    bad_len = bad_len % dbrd_pkg::PREFIX_LEN;
                send_length(bad_len, 1'($urandom_range(1)));
            end
            else if (pick < 20)
                send_message($urandom_range(64, 300));
            else if (pick < 30)
                send_message(0);
            else
                send_message($urandom_range(1, 16));
        end
        no_idle = 1'b0;
        byte_valid = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_short_lengths();
        test_empty_body();
        test_random_traffic();

        // Drain, then allow for the pipeline latency
        wait (expected_replies.size() == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
